[src/pcrh_pkg.sv]
// ----------------------------------------------------------------------------
// pcrh_pkg
// Shared types and constants of the PC sampling range histogram.
// ----------------------------------------------------------------------------
package pcrh_pkg;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 9;
    localparam int PC_W       = 16;
    localparam int SHIFT_W    = 5;
    localparam int RIU_W      = 10;
    localparam int OUT_W      = 48;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Sampling limits and register reset values
    localparam logic [SHIFT_W-1:0] MAX_SHIFT   = 5'd16;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd6;

    // Register index, taken from paddr[2]
    localparam logic REG_SAMPLE_SHIFT  = 1'b0;
    localparam logic REG_RANGES_IN_USE = 1'b1;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_RETIRE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    // Control part of an item travelling along the cell row
    typedef struct packed {
        logic                 valid;
        cmd_t                 cmd;
        logic [IDX_W-1:0]     idx;
        logic                 sampled;
        logic                 hit;
    } token_ctrl_t;

endpackage

[src/pcrh_sampler.sv]
// ----------------------------------------------------------------------------
// pcrh_sampler
// Retire counter and sample decision; builds the item that enters the row.
// ----------------------------------------------------------------------------
module pcrh_sampler #(
    parameter int DATA_W = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [pcrh_pkg::CMD_W-1:0]    command,
    input  logic [pcrh_pkg::IDX_W-1:0]    entry_index,
    input  logic [pcrh_pkg::PC_W-1:0]     range_start,
    input  logic [pcrh_pkg::PC_W-1:0]     range_end,
    input  logic [pcrh_pkg::PC_W-1:0]     pc,
    input  logic [pcrh_pkg::SHIFT_W-1:0]  sample_shift,
    output pcrh_pkg::token_ctrl_t         tok_ctrl,
    output logic [DATA_W-1:0]             tok_data
);
    import pcrh_pkg::*;

    logic [PC_W-1:0] retire_cnt_reg;
    logic [PC_W-1:0] retire_cnt_next;
    logic [PC_W-1:0] sample_mask;
    logic            is_retire;
    logic            take_sample;
    cmd_t            cmd;

    assign cmd       = cmd_t'(command);
    assign is_retire = accept && (cmd == CMD_RETIRE);

    // Mask of the low shift bits; shifts of 16 and above sample once per wrap
    always_comb
    begin
        if (sample_shift >= MAX_SHIFT)
        begin
            sample_mask = '1;
        end
        else
        begin
            sample_mask = (PC_W'(1) << sample_shift[3:0]) - PC_W'(1);
        end
    end

    assign retire_cnt_next = is_retire ? retire_cnt_reg + PC_W'(1) : retire_cnt_reg;
    assign take_sample     = ((retire_cnt_reg + PC_W'(1)) & sample_mask) == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retire_cnt_reg <= '0;
        end
        else
        begin
            retire_cnt_reg <= retire_cnt_next;
        end
    end

    // Item into the first cell
    always_comb
    begin
        tok_ctrl.valid   = accept;
        tok_ctrl.cmd     = cmd;
        tok_ctrl.idx     = entry_index;
        tok_ctrl.sampled = is_retire && take_sample;
        tok_ctrl.hit     = 1'b0;
        case (cmd)
            CMD_LOAD:   tok_data = DATA_W'({range_end, range_start});
            CMD_RETIRE: tok_data = DATA_W'(pc);
            default:    tok_data = '0;
        endcase
    end

endmodule

[src/pcrh_cell.sv]
// ----------------------------------------------------------------------------
// pcrh_cell
// One table entry: range bounds and sample counter. Matches, loads or reads
// the passing item, then hands it to the next cell.
// ----------------------------------------------------------------------------
module pcrh_cell #(
    parameter int CELL_IDX   = 0,
    parameter int COUNT_BITS = 48,
    parameter int DATA_W     = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pcrh_pkg::RIU_W-1:0]   ranges_in_use,
    input  pcrh_pkg::token_ctrl_t        in_ctrl,
    input  logic [DATA_W-1:0]            in_data,
    output pcrh_pkg::token_ctrl_t        out_ctrl,
    output logic [DATA_W-1:0]            out_data
);
    import pcrh_pkg::*;

    logic [PC_W-1:0]       start_reg;
    logic [PC_W-1:0]       start_next;
    logic [PC_W-1:0]       end_reg;
    logic [PC_W-1:0]       end_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    token_ctrl_t           ctrl_reg;
    token_ctrl_t           ctrl_next;
    logic [DATA_W-1:0]     data_reg;
    logic [DATA_W-1:0]     data_next;
    logic                  active;
    logic                  addressed;
    logic                  match;
    logic [PC_W-1:0]       pc;

    // Entry takes part in matching when below ranges_in_use
    assign active    = 32'(ranges_in_use) > 32'(CELL_IDX);
    assign addressed = in_ctrl.valid && (32'(in_ctrl.idx) == 32'(CELL_IDX));
    assign pc        = in_data[PC_W-1:0];

    // First active range holding a sampled pc claims it
    assign match = in_ctrl.valid && (in_ctrl.cmd == CMD_RETIRE) && in_ctrl.sampled
                   && !in_ctrl.hit && active
                   && (pc >= start_reg) && (pc < end_reg);

    // Entry state update
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        count_next = count_reg;
        if (addressed && (in_ctrl.cmd == CMD_LOAD))
        begin
            start_next = in_data[PC_W-1:0];
            end_next   = in_data[2*PC_W-1:PC_W];
            count_next = '0;
        end
        else if (match && (count_reg != '1))
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
    end

    // Item passed on
    always_comb
    begin
        ctrl_next = in_ctrl;
        data_next = in_data;
        if (match)
        begin
            ctrl_next.hit = 1'b1;
            ctrl_next.idx = IDX_W'(CELL_IDX);
        end
        if (addressed && (in_ctrl.cmd == CMD_READ))
        begin
            data_next = DATA_W'(count_reg);
        end
    end

    // Range bounds: undefined until loaded
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        data_reg  <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ctrl_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_data = data_reg;

endmodule

[src/pcrh_tally.sv]
// ----------------------------------------------------------------------------
// pcrh_tally
// Total and unattributed counters at the end of the row, and the result
// registers.
// ----------------------------------------------------------------------------
module pcrh_tally #(
    parameter int COUNT_BITS = 48,
    parameter int DATA_W     = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pcrh_pkg::token_ctrl_t        in_ctrl,
    input  logic [DATA_W-1:0]            in_data,
    output logic                         done,
    output logic                         sampled,
    output logic                         hit,
    output logic [pcrh_pkg::IDX_W-1:0]   hit_index,
    output logic [pcrh_pkg::OUT_W-1:0]   entry_count,
    output logic [pcrh_pkg::OUT_W-1:0]   total_count,
    output logic [pcrh_pkg::OUT_W-1:0]   unattributed_count
);
    import pcrh_pkg::*;

    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;
    logic [COUNT_BITS-1:0] unmatched_reg;
    logic [COUNT_BITS-1:0] unmatched_next;
    logic                  done_reg;
    logic                  sampled_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_index_reg;
    logic [OUT_W-1:0]      entry_count_reg;
    logic [OUT_W-1:0]      total_count_reg;
    logic [OUT_W-1:0]      unattr_count_reg;
    logic                  is_sample;

    assign is_sample = in_ctrl.valid && in_ctrl.sampled;

    // Saturating totals
    always_comb
    begin
        total_next     = total_reg;
        unmatched_next = unmatched_reg;
        if (is_sample && (total_reg != '1))
        begin
            total_next = total_reg + COUNT_BITS'(1);
        end
        if (is_sample && !in_ctrl.hit && (unmatched_reg != '1))
        begin
            unmatched_next = unmatched_reg + COUNT_BITS'(1);
        end
    end

    // Totals and done update every cycle; the other result registers load only when an item leaves the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg        <= '0;
            unmatched_reg    <= '0;
            done_reg         <= 1'b0;
            sampled_reg      <= 1'b0;
            hit_reg          <= 1'b0;
            hit_index_reg    <= '0;
            entry_count_reg  <= '0;
            total_count_reg  <= '0;
            unattr_count_reg <= '0;
        end
        else
        begin
            total_reg     <= total_next;
            unmatched_reg <= unmatched_next;
            done_reg      <= in_ctrl.valid;
            if (in_ctrl.valid)
            begin
                sampled_reg      <= is_sample;
                hit_reg          <= is_sample && in_ctrl.hit;
                hit_index_reg    <= (is_sample && in_ctrl.hit) ? in_ctrl.idx : '0;
                entry_count_reg  <= (in_ctrl.cmd == CMD_READ)
                                    ? OUT_W'(in_data[COUNT_BITS-1:0]) : '0;
                total_count_reg  <= OUT_W'(total_next);
                unattr_count_reg <= OUT_W'(unmatched_next);
            end
        end
    end

    assign done               = done_reg;
    assign sampled            = sampled_reg;
    assign hit                = hit_reg;
    assign hit_index          = hit_index_reg;
    assign entry_count        = entry_count_reg;
    assign total_count        = total_count_reg;
    assign unattributed_count = unattr_count_reg;

endmodule

[src/pc_sample_range_histogram_top.sv]
// ----------------------------------------------------------------------------
// pc_sample_range_histogram_top
// PC sampling profiler with an address-range histogram.
// ----------------------------------------------------------------------------
// An item (load, retire or read) is accepted in every cycle in which start is
// high; busy stays low. Each item walks a row of NUM_RANGES cells, one cell a
// cycle, then passes the tally registers, and its result appears on the result
// ports with done high for one cycle. Results come back in acceptance order and
// the length of the cell row sets how long an item takes to return. done cannot
// be held off, so results must be taken as they come. Write
// sample_shift and ranges_in_use only once every accepted item has returned.
// ----------------------------------------------------------------------------
module pc_sample_range_histogram_top #(
    parameter int NUM_RANGES = 512,
    parameter int COUNT_BITS = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcrh_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pcrh_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pcrh_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Items in
    input  logic                              start,
    output logic                              busy,
    input  logic [pcrh_pkg::CMD_W-1:0]        command,
    input  logic [pcrh_pkg::IDX_W-1:0]        entry_index,
    input  logic [pcrh_pkg::PC_W-1:0]         range_start,
    input  logic [pcrh_pkg::PC_W-1:0]         range_end,
    input  logic [pcrh_pkg::PC_W-1:0]         pc,
    // Results out
    output logic                              done,
    output logic                              sampled,
    output logic                              hit,
    output logic [pcrh_pkg::IDX_W-1:0]        hit_index,
    output logic [pcrh_pkg::OUT_W-1:0]        entry_count,
    output logic [pcrh_pkg::OUT_W-1:0]        total_count,
    output logic [pcrh_pkg::OUT_W-1:0]        unattributed_count
);
    import pcrh_pkg::*;

    // Data word carries {end, start}, a pc, or a counter
    localparam int DATA_W = (COUNT_BITS > 2*PC_W) ? COUNT_BITS : 2*PC_W;

    logic [SHIFT_W-1:0] sample_shift_reg;
    logic [RIU_W-1:0]   ranges_in_use_reg;
    logic               cfg_write;
    logic               accept;

    token_ctrl_t        chain_ctrl [NUM_RANGES+1];
    logic [DATA_W-1:0]  chain_data [NUM_RANGES+1];

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_shift_reg  <= SHIFT_RESET;
            ranges_in_use_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_SAMPLE_SHIFT:  sample_shift_reg  <= pwdata[SHIFT_W-1:0];
                REG_RANGES_IN_USE: ranges_in_use_reg <= pwdata[RIU_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SAMPLE_SHIFT:  prdata = APB_DATA_W'(sample_shift_reg);
            REG_RANGES_IN_USE: prdata = APB_DATA_W'(ranges_in_use_reg);
            default:           prdata = '0;
        endcase
    end

    // Every cycle can take an item
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Sample decision and entry into the row
    pcrh_sampler #(
        .DATA_W       (DATA_W)
    ) u_sampler (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command      (command),
        .entry_index  (entry_index),
        .range_start  (range_start),
        .range_end    (range_end),
        .pc           (pc),
        .sample_shift (sample_shift_reg),
        .tok_ctrl     (chain_ctrl[0]),
        .tok_data     (chain_data[0])
    );

    // Row of range cells
    for (genvar i = 0; i < NUM_RANGES; i++)
    begin : g_cell
        pcrh_cell #(
            .CELL_IDX      (i),
            .COUNT_BITS    (COUNT_BITS),
            .DATA_W        (DATA_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ranges_in_use (ranges_in_use_reg),
            .in_ctrl       (chain_ctrl[i]),
            .in_data       (chain_data[i]),
            .out_ctrl      (chain_ctrl[i+1]),
            .out_data      (chain_data[i+1])
        );
    end

    // Totals and result registers
    pcrh_tally #(
        .COUNT_BITS         (COUNT_BITS),
        .DATA_W             (DATA_W)
    ) u_tally (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_ctrl            (chain_ctrl[NUM_RANGES]),
        .in_data            (chain_data[NUM_RANGES]),
        .done               (done),
        .sampled            (sampled),
        .hit                (hit),
        .hit_index          (hit_index),
        .entry_count        (entry_count),
        .total_count        (total_count),
        .unattributed_count (unattributed_count)
    );

endmodule

[src/pcrh_checker.sv]
// ----------------------------------------------------------------------------
// pcrh_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pcrh_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              done,
    input  logic                              sampled,
    input  logic                              hit,
    input  logic [pcrh_pkg::IDX_W-1:0]        hit_index,
    input  logic [pcrh_pkg::OUT_W-1:0]        entry_count,
    input  logic [pcrh_pkg::OUT_W-1:0]        total_count,
    input  logic [pcrh_pkg::OUT_W-1:0]        unattributed_count
);
    import pcrh_pkg::*;

    // A hit only ever comes from a sample
    a_hit_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> sampled)
        else $error("hit without a sample");

    // Index is cleared when nothing matched
    a_idx_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> hit_index == '0)
        else $error("hit_index set without a hit");

    // A sample is a retire, never a read
    a_sample_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && sampled |-> entry_count == '0)
        else $error("entry_count set on a sample");

    // Totals change only with a result
    a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> $stable(total_count) && $stable(unattributed_count))
        else $error("totals changed without a result");

endmodule

bind pc_sample_range_histogram_top pcrh_checker u_pcrh_checker (.*);

[bench/tb_pc_sample_range_histogram_top.sv]
// ----------------------------------------------------------------------------
// tb_pc_sample_range_histogram_top
// Self-checking bench for the PC sampling range histogram.
// ----------------------------------------------------------------------------
// Every accepted item is run through a behavioural copy of the profiler and
// the counters it should produce are queued. Results leaving on done are
// checked in order against that queue, field by field. A short table of
// directed items comes first, then the whole range table is filled, then
// phases of random traffic under different sampling and range settings, and
// last an unbroken run of retires while the widest sampling interval is
// selected.
// ----------------------------------------------------------------------------
module tb_pc_sample_range_histogram_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcrh_pkg::*;

    localparam int RANGES       = 512;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 40;
    localparam int TAIL_ITEMS   = 100;
    localparam int DIR_ROWS     = 28;

    // Command code the block does not decode
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] entry_index;
        logic [PC_W-1:0]  range_start;
        logic [PC_W-1:0]  range_end;
        logic [PC_W-1:0]  pc;
    } item_t;

    typedef struct packed {
        logic             sampled;
        logic             hit;
        logic [IDX_W-1:0] hit_index;
        logic [OUT_W-1:0] entry_count;
        logic [OUT_W-1:0] total_count;
        logic [OUT_W-1:0] unattributed_count;
    } counts_t;

    typedef enum logic [1:0] {
        ROW_ITEM,   // item checked against the predictor
        ROW_FIXED,  // item with its result given in the row
        ROW_CFG     // register write
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic                  reg_sel;
        logic [APB_DATA_W-1:0] reg_value;
        item_t                 item;
        counts_t               want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      command;
    logic [IDX_W-1:0]      entry_index;
    logic [PC_W-1:0]       range_start;
    logic [PC_W-1:0]       range_end;
    logic [PC_W-1:0]       pc;
    logic                  done;
    logic                  sampled;
    logic                  hit;
    logic [IDX_W-1:0]      hit_index;
    logic [OUT_W-1:0]      entry_count;
    logic [OUT_W-1:0]      total_count;
    logic [OUT_W-1:0]      unattributed_count;

    // Behavioural copy of the profiler state
    logic [PC_W-1:0]    lo_addr   [RANGES];
    logic [PC_W-1:0]    hi_addr   [RANGES];
    logic [OUT_W-1:0]   bin_count [RANGES];
    logic [PC_W-1:0]    retire_seen;
    logic [OUT_W-1:0]   total_seen;
    logic [OUT_W-1:0]   unmatched_seen;
    logic [SHIFT_W-1:0] shift_cfg;
    logic [RIU_W-1:0]   ranges_cfg;

    counts_t counts_due [$];

    int  mismatches      = 0;
    int  results_checked = 0;
    int  samples_seen    = 0;
    int  hits_seen       = 0;
    int  phases_run      = 0;
    int  cycle_count     = 0;
    bit  steady          = 1'b0;

    // Directed items: reset values, range edges, empty and reversed ranges,
    // priority of the lowest entry, no active ranges, shift above the limit
    row_t directed [DIR_ROWS] = '{
        // straight after reset every counter reads zero
        '{ROW_FIXED, 1'b0, 32'd0, '{CMD_READ, 9'd0, 16'h0000, 16'h0000, 16'h0000}, '0},
        '{ROW_FIXED, 1'b0, 32'd0, '{CMD_READ, 9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF}, '0},
        '{ROW_FIXED, 1'b0, 32'd0, '{CMD_SPARE, 9'h1FF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, '0},
        // one retire is no sample at the reset shift
        '{ROW_FIXED, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'hFFFF}, '0},
        // loads: plain, empty, reversed, full span, top entry
        '{ROW_FIXED, 1'b0, 32'd0, '{CMD_LOAD, 9'd0, 16'h1000, 16'h2000, 16'h0000}, '0},
        '{ROW_FIXED, 1'b0, 32'd0, '{CMD_LOAD, 9'd1, 16'h3000, 16'h3000, 16'h0000}, '0},
        '{ROW_FIXED, 1'b0, 32'd0, '{CMD_LOAD, 9'd2, 16'h5000, 16'h4000, 16'h0000}, '0},
        '{ROW_FIXED, 1'b0, 32'd0, '{CMD_LOAD, 9'd3, 16'h0000, 16'hFFFF, 16'h0000}, '0},
        '{ROW_FIXED, 1'b0, 32'd0, '{CMD_LOAD, 9'd511, 16'hFFFF, 16'h0000, 16'h0000}, '0},
        // every retire sampled, four entries active
        '{ROW_CFG, REG_SAMPLE_SHIFT, 32'd0, '0, '0},
        '{ROW_CFG, REG_RANGES_IN_USE, 32'd4, '0, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'h1000}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'h1FFF}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'h2000}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'h3000}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'h4800}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'h0000}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'hFFFF}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_READ, 9'd0, 16'h0000, 16'h0000, 16'h0000}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_READ, 9'd3, 16'h0000, 16'h0000, 16'h0000}, '0},
        // reload clears the counter
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_LOAD, 9'd0, 16'h1000, 16'h2000, 16'h0000}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_READ, 9'd0, 16'h0000, 16'h0000, 16'h0000}, '0},
        // nothing active, sample is unattributed
        '{ROW_CFG, REG_RANGES_IN_USE, 32'd0, '0, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'h1800}, '0},
        // shift above the limit behaves as the limit
        '{ROW_CFG, REG_SAMPLE_SHIFT, 32'd17, '0, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'h1800}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_RETIRE, 9'd0, 16'h0000, 16'h0000, 16'h1800}, '0},
        '{ROW_ITEM, 1'b0, 32'd0, '{CMD_READ, 9'd511, 16'h0000, 16'h0000, 16'h0000}, '0}
    };

    int shift_plan [PHASES] = '{0, 0, 2, 1, 16, 3, 0, 31, -1, -1};
    int riu_plan   [PHASES] = '{512, 1023, 0, 1, 512, -1, -1, 700, -1, -1};

    pc_sample_range_histogram_top #(
        .NUM_RANGES (RANGES),
        .COUNT_BITS (OUT_W)
    ) dut (.*);

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Counter increment that sticks at all ones
    function automatic logic [OUT_W-1:0] bump(input logic [OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic int active_ranges();
        return (ranges_cfg > RANGES) ? RANGES : int'(ranges_cfg);
    endfunction

    // Apply one item to the state copy and return the counters it yields
    function automatic counts_t tally_item(input item_t it);
        counts_t         r;
        int unsigned     sh;
        logic [PC_W:0]   span;
        r = '0;
        case (it.command)
            CMD_LOAD:
            begin
                lo_addr[it.entry_index]   = it.range_start;
                hi_addr[it.entry_index]   = it.range_end;
                bin_count[it.entry_index] = '0;
            end
            CMD_RETIRE:
            begin
                sh          = (shift_cfg > MAX_SHIFT) ? MAX_SHIFT : shift_cfg;
                span        = (17'd1 << sh) - 17'd1;
                retire_seen = retire_seen + 1'b1;
                if ((retire_seen & span[PC_W-1:0]) == '0)
                begin
                    r.sampled  = 1'b1;
                    total_seen = bump(total_seen);
                    // lowest active entry holding the pc wins
                    for (int i = 0; i < active_ranges(); i++)
                    begin
                        if (!r.hit && it.pc >= lo_addr[i] && it.pc < hi_addr[i])
                        begin
                            bin_count[i] = bump(bin_count[i]);
                            r.hit        = 1'b1;
                            r.hit_index  = IDX_W'(i);
                        end
                    end
                    if (!r.hit)
                        unmatched_seen = bump(unmatched_seen);
                end
            end
            CMD_READ:
            begin
                r.entry_count = bin_count[it.entry_index];
            end
            default:
            begin
            end
        endcase
        r.total_count        = total_seen;
        r.unattributed_count = unmatched_seen;
        return r;
    endfunction

    // Idle cycles between items: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Range of a load: mostly narrow, some wide, empty, reversed or extreme
    function automatic logic [2*PC_W-1:0] random_span();
        logic [PC_W-1:0] lo;
        logic [PC_W-1:0] hi;
        int              k;
        lo = PC_W'($urandom());
        k  = $urandom_range(0, 99);
        if (k < 65)
            hi = lo + PC_W'($urandom_range(1, 300));
        else if (k < 75)
        begin
            lo = PC_W'($urandom_range(16'h0000, 16'h7FFF));
            hi = PC_W'($urandom_range(16'h8000, 16'hFFFF));
        end
        else if (k < 83)
            hi = lo;
        else if (k < 91)
            hi = lo - PC_W'($urandom_range(1, 300));
        else
        begin
            lo = ($urandom_range(0, 1) != 0) ? '1 : '0;
            hi = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        return {lo, hi};
    endfunction

    // Random item; unused fields carry junk
    function automatic item_t random_item();
        item_t       it;
        logic [63:0] noise;
        int          pick;
        int          n;
        int          k;
        int          edge_sel;
        noise = {$urandom(), $urandom()};
        it    = noise[$bits(item_t)-1:0];
        pick  = $urandom_range(0, 99);
        n     = active_ranges();
        if (pick < 15)
        begin
            it.command = CMD_LOAD;
            if (n > 0 && $urandom_range(0, 9) < 6)
                it.entry_index = IDX_W'($urandom_range(0, n - 1));
            {it.range_start, it.range_end} = random_span();
        end
        else if (pick < 72)
        begin
            it.command = CMD_RETIRE;
            // aim most retires at an active range, edges included
            if (n > 0 && $urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, n - 1);
                if (lo_addr[k] < hi_addr[k])
                begin
                    edge_sel = $urandom_range(0, 9);
                    if (edge_sel == 0)
                        it.pc = lo_addr[k];
                    else if (edge_sel == 1)
                        it.pc = hi_addr[k] - 1'b1;
                    else if (edge_sel == 2)
                        it.pc = hi_addr[k];
                    else
                        it.pc = PC_W'($urandom_range(int'(lo_addr[k]),
                                                     int'(hi_addr[k]) - 1));
                end
            end
        end
        else if (pick < 93)
        begin
            it.command = CMD_READ;
            if (n > 0 && $urandom_range(0, 2) != 0)
                it.entry_index = IDX_W'($urandom_range(0, n - 1));
        end
        else
            it.command = CMD_SPARE;
        return it;
    endfunction

    // Present one item, wait for it to be taken, queue its counters
    task automatic issue(input item_t it, input bit fixed, input counts_t want);
        counts_t     predicted;
        logic [63:0] noise;
        int          gap;
        start       <= 1'b1;
        command     <= it.command;
        entry_index <= it.entry_index;
        range_start <= it.range_start;
        range_end   <= it.range_end;
        pc          <= it.pc;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = tally_item(it);
        counts_due.push_back(fixed ? want : predicted);
        gap = idle_gap();
        if (gap > 0)
        begin
            noise       = {$urandom(), $urandom()};
            start       <= 1'b0;
            command     <= noise[1:0];
            entry_index <= noise[10:2];
            range_start <= noise[26:11];
            range_end   <= noise[42:27];
            pc          <= noise[58:43];
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        start <= 1'b0;
        while (counts_due.size() != 0)
            @(posedge clk);
    endtask

    // Register write, then read back
    task automatic write_reg(input logic sel, input int unsigned field);
        logic [APB_DATA_W-1:0] word;
        logic [APB_DATA_W-1:0] readback;
        int                    w;
        w = (sel == REG_SAMPLE_SHIFT) ? SHIFT_W : RIU_W;
        // bits above the register width carry junk
        word = ($urandom() << w) | field;
        // bus idle between transfers
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (sel == REG_SAMPLE_SHIFT)
        begin
            shift_cfg = word[SHIFT_W-1:0];
            readback  = APB_DATA_W'(shift_cfg);
        end
        else
        begin
            ranges_cfg = word[RIU_W-1:0];
            readback   = APB_DATA_W'(ranges_cfg);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== readback)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("register %0d reads %0h, expected %0h", sel, prdata, readback);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        counts_t seen;
        counts_t due;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            seen = {sampled, hit, hit_index, entry_count, total_count,
                    unattributed_count};
            if (counts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result at %0t with no item outstanding", $time);
            end
            else
            begin
                due = counts_due.pop_front();
                results_checked++;
                if (due.sampled)
                    samples_seen++;
                if (due.hit)
                    hits_seen++;
                if (seen !== due)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch at %0t (expected/actual): sampled %0b/%0b",
                                 $time, due.sampled, seen.sampled);
                        $display("  hit %0b/%0b index %0d/%0d entry %0d/%0d",
                                 due.hit, seen.hit, due.hit_index, seen.hit_index,
                                 due.entry_count, seen.entry_count);
                        $display("  total %0d/%0d unattributed %0d/%0d",
                                 due.total_count, seen.total_count,
                                 due.unattributed_count, seen.unattributed_count);
                    end
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        item_t       it;
        int unsigned shift_pick;
        int unsigned riu_pick;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        command     = '0;
        entry_index = '0;
        range_start = '0;
        range_end   = '0;
        pc          = '0;

        for (int i = 0; i < RANGES; i++)
        begin
            lo_addr[i]   = '0;
            hi_addr[i]   = '0;
            bin_count[i] = '0;
        end
        retire_seen    = '0;
        total_seen     = '0;
        unmatched_seen = '0;
        shift_cfg      = SHIFT_RESET;
        ranges_cfg     = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[r])
        begin
            if (directed[r].kind == ROW_CFG)
            begin
                settle();
                write_reg(directed[r].reg_sel, directed[r].reg_value);
            end
            else
                issue(directed[r].item, directed[r].kind == ROW_FIXED, directed[r].want);
        end

        // fill the whole table so any range count may be selected
        for (int i = 0; i < RANGES; i++)
        begin
            it             = random_item();
            it.command     = CMD_LOAD;
            it.entry_index = IDX_W'(i);
            {it.range_start, it.range_end} = random_span();
            issue(it, 1'b0, '0);
        end

        // random phases
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (shift_plan[p] >= 0)
                shift_pick = shift_plan[p];
            else if ($urandom_range(0, 3) == 0)
                shift_pick = $urandom_range(0, 31);
            else
                shift_pick = $urandom_range(0, 4);
            riu_pick = (riu_plan[p] >= 0) ? riu_plan[p] : $urandom_range(0, 1023);
            write_reg(REG_SAMPLE_SHIFT, shift_pick);
            write_reg(REG_RANGES_IN_USE, riu_pick);
            steady = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) issue(random_item(), 1'b0, '0);
            steady = 1'b0;
            phases_run++;
        end

        // back-to-back retires at the widest interval
        settle();
        write_reg(REG_SAMPLE_SHIFT, $urandom_range(MAX_SHIFT, 31));
        write_reg(REG_RANGES_IN_USE, RANGES);
        steady = 1'b1;
        repeat (TAIL_ITEMS)
        begin
            it         = random_item();
            it.command = CMD_RETIRE;
            issue(it, 1'b0, '0);
        end
        steady = 1'b0;

        settle();
        // a full pass of the cell row with nothing outstanding
        repeat (RANGES + 8) @(posedge clk);

        $display("%0d results checked: directed items, table fill, %0d random phases, %s",
                 results_checked, phases_run, "widest-interval retire run");
        $display("%0d samples taken, %0d of them inside an active range",
                 samples_seen, hits_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
